// ===== src/sbh_pkg.sv =====
`default_nettype none
package sbh_pkg;

   localparam int HashW   = 32;
   localparam int BucketW = 16;
   localparam int ByteW   = 8;
   localparam int CntW    = $clog2(HashW);

   // bucket count used when the register holds zero, and its reset value
   localparam logic [BucketW-1:0] DefaultBuckets = BucketW'(255);

   // controller to datapath commands
   typedef struct packed {
      logic mix;        // mix the accepted request byte into the running hash
      logic clear_key;  // empty key: zero hash and result
      logic finish;     // apply final avalanche and start the divider
      logic step;       // one restoring divide step
      logic load_out;   // move result into the output register
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic div_last;   // current divide step is the last one
   } status_type;

endpackage
`default_nettype wire

// ===== src/sbh_ctrl.sv =====
`default_nettype none
module sbh_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_last_byte,
   input  wire logic               req_empty_key,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output sbh_pkg::cmd_type        cmd,
   input  wire sbh_pkg::status_type status
);

   typedef enum logic [1:0] {
      IDLE,
      FINISH,
      DIVIDE,
      DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;
   logic      out_free;

   assign req_stall = (state_ff != IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // decode commands and next state
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         IDLE: begin
            if (accept) begin
               if (req_empty_key) begin
                  cmd.clear_key = 1'b1;
                  state_in      = DONE;
               end else begin
                  cmd.mix = 1'b1;
                  if (req_last_byte) begin
                     state_in = FINISH;
                  end
               end
            end
         end
         FINISH: begin
            cmd.finish = 1'b1;
            state_in   = DIVIDE;
         end
         DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = DONE;
            end
         end
         DONE: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   // hold the result valid until taken
   always_comb begin
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== src/sbh_datapath.sv =====
`default_nettype none
module sbh_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [sbh_pkg::ByteW-1:0]     req_key_byte,
   input  wire logic                          csr_we,
   input  wire logic [sbh_pkg::BucketW-1:0]   csr_wdata,
   input  wire sbh_pkg::cmd_type              cmd,
   output sbh_pkg::status_type                status,
   output logic [sbh_pkg::BucketW-1:0]        rsp_bucket_index,
   output logic [sbh_pkg::HashW-1:0]          rsp_full_hash
);

   logic [sbh_pkg::HashW-1:0]   hash_ff, hash_in;
   logic [sbh_pkg::HashW-1:0]   full_ff, full_in;
   logic [sbh_pkg::HashW-1:0]   quo_ff, quo_in;
   logic [sbh_pkg::BucketW-1:0] rem_ff, rem_in;
   logic [sbh_pkg::BucketW-1:0] div_ff, div_in;
   logic [sbh_pkg::CntW-1:0]    cnt_ff, cnt_in;
   logic [sbh_pkg::BucketW-1:0] bucket_count_ff;
   logic [sbh_pkg::BucketW-1:0] out_index_ff;
   logic [sbh_pkg::HashW-1:0]   out_hash_ff;

   logic [sbh_pkg::HashW-1:0]   mixed;
   logic [sbh_pkg::HashW-1:0]   finished;
   logic [sbh_pkg::BucketW:0]   shifted;
   logic [sbh_pkg::BucketW:0]   diff;

   // one round of the byte mix, byte taken as signed char
   function automatic logic [sbh_pkg::HashW-1:0] mix_byte(
      input logic [sbh_pkg::HashW-1:0] h,
      input logic [sbh_pkg::ByteW-1:0] b
   );
      logic [sbh_pkg::HashW-1:0] v;
      v = {{(sbh_pkg::HashW-sbh_pkg::ByteW){b[sbh_pkg::ByteW-1]}}, b};
      h = h + v;
      h = h + (h << 10);
      h = h ^ (h >> 6);
      return h;
   endfunction

   // final avalanche
   function automatic logic [sbh_pkg::HashW-1:0] finish_hash(
      input logic [sbh_pkg::HashW-1:0] h
   );
      h = h + (h << 3);
      h = h ^ (h >> 11);
      h = h + (h << 15);
      return h;
   endfunction

   assign mixed    = mix_byte(hash_ff, req_key_byte);
   assign finished = finish_hash(hash_ff);

   // restoring divide step: shift in next dividend bit, subtract if it fits
   assign shifted = {rem_ff, quo_ff[sbh_pkg::HashW-1]};
   assign diff    = shifted - {1'b0, div_ff};

   assign status.div_last = (cnt_ff == sbh_pkg::CntW'(sbh_pkg::HashW - 1));

   // advance hash and divider
   always_comb begin
      hash_in = hash_ff;
      full_in = full_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      cnt_in  = cnt_ff;
      if (cmd.mix) begin
         hash_in = mixed;
      end
      if (cmd.clear_key) begin
         hash_in = '0;
         full_in = '0;
         rem_in  = '0;
      end
      if (cmd.finish) begin
         hash_in = '0;
         full_in = finished;
         quo_in  = finished;
         rem_in  = '0;
         cnt_in  = '0;
         div_in  = (bucket_count_ff == '0) ? sbh_pkg::DefaultBuckets : bucket_count_ff;
      end
      if (cmd.step) begin
         quo_in = {quo_ff[sbh_pkg::HashW-2:0], 1'b0};
         rem_in = diff[sbh_pkg::BucketW] ? shifted[sbh_pkg::BucketW-1:0]
                                         : diff[sbh_pkg::BucketW-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   // hold running hash and bucket count
   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff         <= '0;
         bucket_count_ff <= sbh_pkg::DefaultBuckets;
      end else begin
         hash_ff <= hash_in;
         if (csr_we) begin
            bucket_count_ff <= csr_wdata;
         end
      end
   end

   // divider and output payload
   always_ff @(posedge clock) begin
      full_ff <= full_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      cnt_ff  <= cnt_in;
      if (cmd.load_out) begin
         out_index_ff <= rem_ff;
         out_hash_ff  <= full_ff;
      end
   end

   assign rsp_bucket_index = out_index_ff;
   assign rsp_full_hash    = out_hash_ff;

endmodule
`default_nettype wire

// ===== src/string_bucket_hash.sv =====
`default_nettype none
// One-at-a-time string hash with bucket selection. Key bytes enter one per
// request; a byte that does not end the key leaves the next request free to
// be taken. A byte that ends the key is followed by the final avalanche, a
// bit-serial restoring divider for the modulo, and the load of the output
// register, which waits while a held response is stalled; the next request
// is taken only after that load. An empty key yields hash 0 and index 0 and
// blocks requests until the output register is loaded. The bucket count is
// latched when the divider starts; zero selects 255, reset is 255. The
// running hash returns to zero after every key end.
module string_bucket_hash (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_stall,
   input  wire logic [sbh_pkg::ByteW-1:0]   req_key_byte,
   input  wire logic                        req_last_byte,
   input  wire logic                        req_empty_key,
   output logic                             rsp_valid,
   input  wire logic                        rsp_stall,
   output logic [sbh_pkg::BucketW-1:0]      rsp_bucket_index,
   output logic [sbh_pkg::HashW-1:0]        rsp_full_hash,
   input  wire logic                        csr_we,
   input  wire logic [sbh_pkg::BucketW-1:0] csr_wdata
);

   sbh_pkg::cmd_type    cmd;
   sbh_pkg::status_type status;

   sbh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_last_byte (req_last_byte),
      .req_empty_key (req_empty_key),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .cmd           (cmd),
      .status        (status)
   );

   sbh_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .req_key_byte     (req_key_byte),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .cmd              (cmd),
      .status           (status),
      .rsp_bucket_index (rsp_bucket_index),
      .rsp_full_hash    (rsp_full_hash)
   );

   // a key-ending request blocks the next cycle
   a_key_end_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_last_byte || req_empty_key) |=> req_stall)
      else $error("request taken right after key end");

   // commands from the controller never overlap
   a_cmd_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.mix, cmd.clear_key, cmd.finish, cmd.step, cmd.load_out}))
      else $error("overlapping datapath commands");

   // a zero hash always maps to bucket zero
   a_zero_hash: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_full_hash == '0) |-> (rsp_bucket_index == '0))
      else $error("nonzero bucket for zero hash");

endmodule
`default_nettype wire
